### design/wqm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the waypoint queue manager.
package wqm_pkg;

	localparam int COORD_W = 24;
	localparam int LIMIT_W = 23;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int IN_TDATA_W = 3 * COORD_W;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_POSE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RETAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REACH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_LIMIT = 3'd5;

	// Register reset values, Q15.8
	localparam logic [LIMIT_W-1:0] RST_REACH = 23'd128;
	localparam logic [LIMIT_W-1:0] RST_SPACING = 23'd128;
	localparam logic [LIMIT_W-1:0] RST_X_LIMIT = 23'd64000;
	localparam logic [LIMIT_W-1:0] RST_Y_LIMIT = 23'd64000;
	localparam logic [LIMIT_W-1:0] RST_Z_LIMIT = 23'd12800;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	// x in the low bits, matching the word layout
	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;

	typedef struct packed {
		logic capture;
		logic square;
		logic commit;
		logic refill;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_refill;
	} dp_status_t;

endpackage

### design/wqm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the waypoint queue manager: handshakes and stage commands.
module wqm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  wqm_pkg::dp_status_t   status,
	output wqm_pkg::ctl_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DECIDE,
		ST_REFILL
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_DECIDE: s_tready = out_free && !status.need_refill;
			ST_REFILL: s_tready = 1'b1;
			default:   s_tready = 1'b0;
		endcase
		cmd.capture = s_tvalid && s_tready;
		cmd.square  = (state_q == ST_SQUARE);
		cmd.commit  = (state_q == ST_DECIDE) && out_free;
		cmd.refill  = (state_q == ST_REFILL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					// hold the decision until the output word is free
					if (out_free) begin
						if (status.need_refill) begin
							state_q <= ST_REFILL;
						end else begin
							m_tvalid <= 1'b1;
							state_q  <= s_tvalid ? ST_SQUARE : ST_IDLE;
						end
					end
				end
				ST_REFILL: begin
					m_tvalid <= 1'b1;
					state_q  <= s_tvalid ? ST_SQUARE : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/wqm_dpath.sv
`timescale 1ns / 1ps
// Datapath: waypoint store, queue pointers, squared distances and result word.
module wqm_dpath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int AW = $clog2(QUEUE_DEPTH),
	parameter int CW = $clog2(QUEUE_DEPTH + 1),
	parameter int RES_W = 3 + 3 * wqm_pkg::COORD_W + CW
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wqm_pkg::ctl_cmd_t                 cmd,
	output wqm_pkg::dp_status_t               status,
	input  logic [wqm_pkg::MODE_W-1:0]        in_mode,
	input  wqm_pkg::point_t                   in_pos,
	input  logic                              cfg_we,
	input  logic [wqm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wqm_pkg::LIMIT_W-1:0]       cfg_wdata,
	output logic [RES_W-1:0]                  out_word
);

	localparam int SQ_W = 2 * wqm_pkg::COORD_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int RSQ_W = 2 * wqm_pkg::LIMIT_W;

	function automatic logic [wqm_pkg::COORD_W-1:0] abs_diff(
		input wqm_pkg::coord_t a,
		input wqm_pkg::coord_t b
	);
		logic [wqm_pkg::COORD_W:0] d;
		logic [wqm_pkg::COORD_W:0] n;
		d = {a[wqm_pkg::COORD_W-1], a} - {b[wqm_pkg::COORD_W-1], b};
		n = ~d + 1'b1;
		return d[wqm_pkg::COORD_W] ? n[wqm_pkg::COORD_W-1:0] : d[wqm_pkg::COORD_W-1:0];
	endfunction

	function automatic logic [wqm_pkg::COORD_W-1:0] mag(input wqm_pkg::coord_t v);
		return v[wqm_pkg::COORD_W-1] ? (~v + 1'b1) : v;
	endfunction

	// configuration
	logic               retain_q;
	wqm_pkg::limit_t    reach_q;
	wqm_pkg::limit_t    spacing_q;
	wqm_pkg::limit_t    xlim_q;
	wqm_pkg::limit_t    ylim_q;
	wqm_pkg::limit_t    zlim_q;

	// queue state
	wqm_pkg::point_t    mem [QUEUE_DEPTH];
	wqm_pkg::point_t    rd_q;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic               flag_q;
	wqm_pkg::point_t    pose_q;
	wqm_pkg::point_t    front_q;
	wqm_pkg::point_t    tail_q;

	// captured item and squares
	logic [wqm_pkg::MODE_W-1:0] mode_q;
	wqm_pkg::point_t    pos_q;
	wqm_pkg::point_t    anchor;
	logic [SQ_W-1:0]    sqx_s1;
	logic [SQ_W-1:0]    sqy_s1;
	logic [SQ_W-1:0]    sqz_s1;
	logic [RSQ_W-1:0]   rsq_s1;
	logic               lim_ok_s1;

	// decision
	logic [SUM_W-1:0]   dsum;
	logic               near;
	logic               far;
	logic [AW-1:0]      head_inc;
	logic [CW:0]        wsum;
	logic [AW-1:0]      wslot;
	logic [AW-1:0]      head_n;
	logic [CW-1:0]      count_n;
	logic               flag_n;
	logic               acc_n;
	logic               refill_n;
	wqm_pkg::point_t    pose_n;
	wqm_pkg::point_t    front_n;
	wqm_pkg::point_t    tail_n;
	logic               we;
	logic [AW-1:0]      waddr;
	wqm_pkg::point_t    wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retain_q  <= 1'b0;
			reach_q   <= wqm_pkg::RST_REACH;
			spacing_q <= wqm_pkg::RST_SPACING;
			xlim_q    <= wqm_pkg::RST_X_LIMIT;
			ylim_q    <= wqm_pkg::RST_Y_LIMIT;
			zlim_q    <= wqm_pkg::RST_Z_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				wqm_pkg::CFG_RETAIN:  retain_q  <= cfg_wdata[0];
				wqm_pkg::CFG_REACH:   reach_q   <= cfg_wdata;
				wqm_pkg::CFG_SPACING: spacing_q <= cfg_wdata;
				wqm_pkg::CFG_X_LIMIT: xlim_q    <= cfg_wdata;
				wqm_pkg::CFG_Y_LIMIT: ylim_q    <= cfg_wdata;
				wqm_pkg::CFG_Z_LIMIT: zlim_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pose reports measure against the front, adds against the tail
	assign anchor = (mode_q == wqm_pkg::MODE_POSE) ? front_q : tail_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			pos_q  <= in_pos;
		end
		if (cmd.square) begin
			sqx_s1 <= SQ_W'(abs_diff(pos_q.x, anchor.x)) * SQ_W'(abs_diff(pos_q.x, anchor.x));
			sqy_s1 <= SQ_W'(abs_diff(pos_q.y, anchor.y)) * SQ_W'(abs_diff(pos_q.y, anchor.y));
			sqz_s1 <= SQ_W'(abs_diff(pos_q.z, anchor.z)) * SQ_W'(abs_diff(pos_q.z, anchor.z));
			if (mode_q == wqm_pkg::MODE_POSE)
				rsq_s1 <= RSQ_W'(reach_q) * RSQ_W'(reach_q);
			else
				rsq_s1 <= RSQ_W'(spacing_q) * RSQ_W'(spacing_q);
			lim_ok_s1 <= (mag(pos_q.x) < {1'b0, xlim_q}) &&
			             (mag(pos_q.y) < {1'b0, ylim_q}) &&
			             (mag(pos_q.z) < {1'b0, zlim_q});
		end
	end

	assign dsum = SUM_W'(sqx_s1) + SUM_W'(sqy_s1) + SUM_W'(sqz_s1);
	assign near = dsum < SUM_W'(rsq_s1);
	assign far  = dsum > SUM_W'(rsq_s1);

	assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign wsum  = (CW + 1)'(head_q) + (CW + 1)'(count_q);
	assign wslot = (wsum >= (CW + 1)'(QUEUE_DEPTH)) ?
	               AW'(wsum - (CW + 1)'(QUEUE_DEPTH)) : AW'(wsum);

	always_comb begin
		head_n   = head_q;
		count_n  = count_q;
		flag_n   = flag_q;
		acc_n    = 1'b1;
		refill_n = 1'b0;
		pose_n   = pose_q;
		front_n  = front_q;
		tail_n   = tail_q;
		we       = 1'b0;
		waddr    = head_q;
		wdata    = pos_q;
		case (mode_q)
			wqm_pkg::MODE_POSE: begin
				pose_n = pos_q;
				if (count_q != '0 && near) begin
					if (!retain_q || count_q > CW'(1)) begin
						head_n   = head_inc;
						count_n  = count_q - 1'b1;
						refill_n = (count_n != '0);
						flag_n   = retain_q ? (count_n > CW'(1)) : (count_n != '0);
					end else begin
						// retained last waypoint reached: mission ends, entry stays
						flag_n = 1'b0;
					end
				end
			end
			wqm_pkg::MODE_ADD: begin
				if (!lim_ok_s1) begin
					acc_n = 1'b0;
				end else if (count_q == '0) begin
					we      = 1'b1;
					count_n = CW'(1);
					flag_n  = 1'b1;
					front_n = pos_q;
					tail_n  = pos_q;
				end else if (!far) begin
					acc_n = 1'b0;
				end else if (!flag_q && count_q == CW'(1) && retain_q) begin
					// idle retained entry is overwritten
					we      = 1'b1;
					flag_n  = 1'b1;
					front_n = pos_q;
					tail_n  = pos_q;
				end else if (count_q < CW'(QUEUE_DEPTH)) begin
					we      = 1'b1;
					waddr   = wslot;
					count_n = count_q + 1'b1;
					flag_n  = 1'b1;
					tail_n  = pos_q;
				end else begin
					acc_n = 1'b0;
				end
			end
			wqm_pkg::MODE_CANCEL: begin
				if (count_q != '0) begin
					count_n = '0;
					flag_n  = 1'b0;
					if (retain_q) begin
						we      = 1'b1;
						wdata   = pose_q;
						count_n = CW'(1);
						front_n = pose_q;
						tail_n  = pose_q;
					end
				end
			end
			default: begin
				acc_n = 1'b0;
			end
		endcase
	end

	assign status.need_refill = refill_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			flag_q  <= 1'b0;
			pose_q  <= '0;
		end else if (cmd.commit) begin
			head_q  <= head_n;
			count_q <= count_n;
			flag_q  <= flag_n;
			pose_q  <= pose_n;
		end
	end

	// store: one write port, one registered read of the new head after a pop
	always_ff @(posedge clk) begin
		if (cmd.commit && we)
			mem[waddr] <= wdata;
		if (cmd.commit)
			rd_q <= mem[head_inc];
	end

	// result word: accepted, mission_active, target_valid, target x/y/z, count
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			front_q  <= front_n;
			tail_q   <= tail_n;
			out_word <= {count_n, (count_n != '0) ? front_n : '0,
			             (count_n != '0), flag_n, acc_n};
		end else if (cmd.refill) begin
			front_q <= rd_q;
			out_word[3 +: 3 * wqm_pkg::COORD_W] <= rd_q;
		end
	end

endmodule

### design/waypoint_queue_manager.sv
`timescale 1ns / 1ps
// Top level of the waypoint queue manager.
// Each input word is squared in the square stage, then committed in the decide/update
//   stage, which waits until the output word is free; a pose report that pops the front and
//   leaves the queue non-empty adds a refill step that loads the new front from the store's
//   registered read port. The next input word can be taken while a result is committed.
// Reset clears queue pointers, pose, mission flag and registers; store contents stay
//   undefined and are never used before being written, so no clearing pass is needed.
module waypoint_queue_manager #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// pos_x [23:0], pos_y [47:24], pos_z [71:48]
	input  logic [wqm_pkg::IN_TDATA_W-1:0]            s_tdata,
	// mode [1:0]
	input  logic [wqm_pkg::MODE_W-1:0]                s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// accepted [0], mission_active [1], target_valid [2], target_x [26:3],
	// target_y [50:27], target_z [74:51], waypoint_count [75 +: CW], zero fill above
	output logic [((3 + 3 * wqm_pkg::COORD_W + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0]
	                                                  m_tdata,
	input  logic                                      cfg_we,
	input  logic [wqm_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [wqm_pkg::LIMIT_W-1:0]               cfg_wdata
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int RES_W = 3 + 3 * wqm_pkg::COORD_W + CW;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	wqm_pkg::ctl_cmd_t   cmd;
	wqm_pkg::dp_status_t status;
	logic [RES_W-1:0]    out_word;

	wqm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	wqm_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CW          (CW),
		.RES_W       (RES_W)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_mode   (s_tuser),
		.in_pos    (wqm_pkg::point_t'(s_tdata)),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_word  (out_word)
	);

	assign m_tdata = OUT_TDATA_W'(out_word);

endmodule

### design/wqm_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result word of the waypoint queue manager, bound to the top.
module wqm_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [((3 + 3 * wqm_pkg::COORD_W + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0]
	                              m_tdata
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TGT_W = 3 * wqm_pkg::COORD_W;

	logic            active;
	logic            tvalid_fld;
	logic [TGT_W-1:0] target;
	logic [CW-1:0]   count;

	assign active     = m_tdata[1];
	assign tvalid_fld = m_tdata[2];
	assign target     = m_tdata[3 +: TGT_W];
	assign count      = m_tdata[3 + TGT_W +: CW];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> count <= CW'(QUEUE_DEPTH))
		else $error("waypoint count above queue depth");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> tvalid_fld == (count != '0))
		else $error("target_valid disagrees with waypoint count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !tvalid_fld |-> target == '0)
		else $error("empty queue reports a nonzero target");

	a_active_has_target: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && active |-> tvalid_fld)
		else $error("mission active with an empty queue");

endmodule

bind waypoint_queue_manager wqm_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_wqm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### sim/waypoint_queue_manager_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the waypoint queue manager: directed table, then random phases.
module waypoint_queue_manager_tb;

	localparam int QUEUE_DEPTH = 16;
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_W = ((75 + COUNT_W + 7) / 8) * 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_WORDS = 200;
	localparam int NUM_PHASES = 8;
	localparam int HOLD_AT_WORD = 700;
	localparam int HOLD_CYCLES = 250;
	localparam logic [wqm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic accepted;
		logic mission_active;
		logic target_valid;
		wqm_pkg::point_t target;
		logic [COUNT_W-1:0] waypoint_count;
	} status_t;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_t;
	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [wqm_pkg::MODE_W-1:0] mode;
		logic [wqm_pkg::CFG_IDX_W-1:0] reg_idx;
		int x, y, z;
		bit typed;
		status_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [wqm_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic [wqm_pkg::MODE_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [wqm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [wqm_pkg::LIMIT_W-1:0] cfg_wdata = '0;

	// mirror of the block: queue, pose, flag, registers
	wqm_pkg::point_t wp_store [QUEUE_DEPTH];
	logic [3:0] wp_head = '0;
	int wp_count = 0;
	wqm_pkg::point_t cur_pose = '0;
	logic mission = 1'b0;
	logic cfg_retain = 1'b0;
	wqm_pkg::limit_t cfg_reach = wqm_pkg::RST_REACH;
	wqm_pkg::limit_t cfg_spacing = wqm_pkg::RST_SPACING;
	wqm_pkg::limit_t cfg_xlim = wqm_pkg::RST_X_LIMIT;
	wqm_pkg::limit_t cfg_ylim = wqm_pkg::RST_Y_LIMIT;
	wqm_pkg::limit_t cfg_zlim = wqm_pkg::RST_Z_LIMIT;

	status_t status_due [$];
	int error_count = 0;
	int words_sent = 0;
	int stall_cycles = 0;
	int rx_hold_left = 0;
	bit rx_hold_done = 1'b0;
	idle_t idle_mode = IDLE_NONE;
	dir_row_t dir_tab [$];
	status_t got;

	// retain, reach, spacing, x, y, z limits per phase
	int phase_cfg [NUM_PHASES][6] = '{
		'{0, 128, 128, 64000, 64000, 12800},
		'{1, 2000, 500, 20000, 20000, 5000},
		'{0, 0, 0, 8388607, 8388607, 8388607},
		'{1, 8388607, 8388607, 8388607, 8388607, 8388607},
		'{0, 3000, 100, 0, 0, 0},
		'{1, 1500, 300, 30000, 30000, 30000},
		'{0, 6000, 1000, 2000, 2000, 2000},
		'{1, 400, 50, 64000, 64000, 12800}
	};

	waypoint_queue_manager #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic longint dist_sq(wqm_pkg::point_t a, wqm_pkg::point_t b);
		longint dx, dy, dz;
		dx = longint'($signed(a.x)) - longint'($signed(b.x));
		dy = longint'($signed(a.y)) - longint'($signed(b.y));
		dz = longint'($signed(a.z)) - longint'($signed(b.z));
		return dx * dx + dy * dy + dz * dz;
	endfunction

	function automatic longint sq(wqm_pkg::limit_t v);
		return longint'(v) * longint'(v);
	endfunction

	function automatic bit under(wqm_pkg::coord_t c, wqm_pkg::limit_t lim);
		longint m;
		m = longint'($signed(c));
		if (m < 0)
			m = -m;
		return m < longint'(lim);
	endfunction

	function automatic void store_append(wqm_pkg::point_t p);
		wp_store[4'(wp_head + wp_count)] = p;
		wp_count++;
	endfunction

	// advance the mirror by one word and return the status it reports
	function automatic status_t queue_apply(logic [wqm_pkg::MODE_W-1:0] mode,
			wqm_pkg::point_t p);
		status_t s;
		logic acc;
		acc = 1'b1;
		case (mode)
			wqm_pkg::MODE_POSE: begin
				cur_pose = p;
				if (wp_count > 0 && dist_sq(cur_pose, wp_store[wp_head]) < sq(cfg_reach)) begin
					if (!cfg_retain || wp_count > 1) begin
						wp_head = wp_head + 4'd1;
						wp_count--;
						mission = (wp_count > 0);
					end
					if (cfg_retain && wp_count == 1 && mission)
						mission = 1'b0;
				end
			end
			wqm_pkg::MODE_ADD: begin
				if (!(under(p.x, cfg_xlim) && under(p.y, cfg_ylim) && under(p.z, cfg_zlim))) begin
					acc = 1'b0;
				end else if (wp_count == 0) begin
					store_append(p);
					mission = 1'b1;
				end else if (dist_sq(p, wp_store[4'(wp_head + wp_count - 1)]) <= sq(cfg_spacing)) begin
					acc = 1'b0;
				end else if (!mission && wp_count == 1 && cfg_retain) begin
					// idle single entry gets replaced in retain mode
					wp_store[wp_head] = p;
					mission = 1'b1;
				end else if (wp_count < QUEUE_DEPTH) begin
					store_append(p);
					mission = 1'b1;
				end else begin
					acc = 1'b0;
				end
			end
			wqm_pkg::MODE_CANCEL: begin
				if (wp_count > 0) begin
					wp_count = 0;
					if (cfg_retain)
						store_append(cur_pose);
					mission = 1'b0;
				end
			end
			default: acc = 1'b0;
		endcase
		s.accepted = acc;
		s.mission_active = mission;
		s.target_valid = (wp_count > 0);
		s.target = (wp_count > 0) ? wp_store[wp_head] : '0;
		s.waypoint_count = COUNT_W'(wp_count);
		return s;
	endfunction

	function automatic status_t empty_status(logic acc);
		status_t s;
		s = '0;
		s.accepted = acc;
		return s;
	endfunction

	function automatic dir_row_t w_row(logic [wqm_pkg::MODE_W-1:0] mode, int x, int y, int z);
		dir_row_t r;
		r.kind = ROW_WORD;
		r.mode = mode;
		r.reg_idx = '0;
		r.x = x;
		r.y = y;
		r.z = z;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic dir_row_t w_row_exp(logic [wqm_pkg::MODE_W-1:0] mode, int x, int y,
			int z, logic acc);
		dir_row_t r;
		r = w_row(mode, x, y, z);
		r.typed = 1'b1;
		r.want = empty_status(acc);
		return r;
	endfunction

	function automatic dir_row_t r_row(logic [wqm_pkg::CFG_IDX_W-1:0] idx, int v);
		dir_row_t r;
		r = w_row(wqm_pkg::MODE_POSE, v, 0, 0);
		r.kind = ROW_REG;
		r.reg_idx = idx;
		return r;
	endfunction

	function automatic wqm_pkg::coord_t rand_coord(wqm_pkg::limit_t lim);
		int l;
		l = int'(lim);
		case ($urandom_range(0, 9))
			0: return wqm_pkg::coord_t'(l);
			1: return wqm_pkg::coord_t'(-l);
			2: return wqm_pkg::coord_t'(l - 1);
			3: return wqm_pkg::coord_t'(1 - l);
			default: return wqm_pkg::coord_t'(int'($urandom_range(0, 2 * l)) - l);
		endcase
	endfunction

	function automatic wqm_pkg::coord_t jitter(wqm_pkg::coord_t c, wqm_pkg::limit_t r);
		return wqm_pkg::coord_t'(int'($signed(c)) + int'($urandom_range(0, 2 * int'(r)))
			- int'(r));
	endfunction

	function automatic wqm_pkg::point_t box_point();
		wqm_pkg::point_t p;
		p.x = rand_coord(cfg_xlim);
		p.y = rand_coord(cfg_ylim);
		p.z = rand_coord(cfg_zlim);
		return p;
	endfunction

	function automatic wqm_pkg::point_t near_point(wqm_pkg::point_t c, wqm_pkg::limit_t r);
		wqm_pkg::point_t p;
		p.x = jitter(c.x, r);
		p.y = jitter(c.y, r);
		p.z = jitter(c.z, r);
		return p;
	endfunction

	// fill segments favor adds, drain segments favor poses close to the front
	task automatic make_random_word(input bit fill_seg,
			output logic [wqm_pkg::MODE_W-1:0] mode, output wqm_pkg::point_t p);
		int u;
		u = $urandom_range(0, 99);
		if (u < 8) begin
			mode = wqm_pkg::MODE_W'($urandom_range(0, 3));
			p.x = wqm_pkg::coord_t'($urandom());
			p.y = wqm_pkg::coord_t'($urandom());
			p.z = wqm_pkg::coord_t'($urandom());
		end else if (u < (fill_seg ? 53 : 23)) begin
			mode = wqm_pkg::MODE_ADD;
			p = box_point();
		end else if (u < (fill_seg ? 68 : 30)) begin
			mode = wqm_pkg::MODE_ADD;
			p = (wp_count > 0) ? near_point(wp_store[4'(wp_head + wp_count - 1)], cfg_spacing)
				: box_point();
		end else if (u < (fill_seg ? 85 : 80)) begin
			mode = wqm_pkg::MODE_POSE;
			p = (wp_count > 0) ? near_point(wp_store[wp_head], cfg_reach) : box_point();
		end else if (u < (fill_seg ? 98 : 97)) begin
			mode = wqm_pkg::MODE_POSE;
			p = box_point();
		end else begin
			mode = wqm_pkg::MODE_CANCEL;
			p = box_point();
		end
	endtask

	task automatic send_word(logic [wqm_pkg::MODE_W-1:0] mode, wqm_pkg::point_t p, bit typed,
			status_t want);
		status_t pred;
		int idle_pct;
		s_tvalid <= 1'b1;
		s_tdata <= p;
		s_tuser <= mode;
		do
			@(posedge clk);
		while (!s_tready);
		pred = queue_apply(mode, p);
		status_due.insert(status_due.size(), typed ? want : pred);
		words_sent++;
		idle_pct = (idle_mode == IDLE_SRC) ? 74 : (idle_mode == IDLE_BOTH) ? 30 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [wqm_pkg::CFG_IDX_W-1:0] idx, int v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= wqm_pkg::limit_t'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wqm_pkg::CFG_RETAIN: cfg_retain = v[0];
			wqm_pkg::CFG_REACH: cfg_reach = wqm_pkg::limit_t'(v);
			wqm_pkg::CFG_SPACING: cfg_spacing = wqm_pkg::limit_t'(v);
			wqm_pkg::CFG_X_LIMIT: cfg_xlim = wqm_pkg::limit_t'(v);
			wqm_pkg::CFG_Y_LIMIT: cfg_ylim = wqm_pkg::limit_t'(v);
			wqm_pkg::CFG_Z_LIMIT: cfg_zlim = wqm_pkg::limit_t'(v);
			default: ;
		endcase
	endtask

	task automatic check_field(string name, longint want, longint actual);
		if (want != actual) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, actual);
			error_count++;
		end
	endtask

	// result side: random stalls plus one long hold-off once traffic is under way
	always @(posedge clk) begin
		if (!rx_hold_done && words_sent >= HOLD_AT_WORD) begin
			rx_hold_done = 1'b1;
			rx_hold_left = HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (idle_mode)
				IDLE_SINK: m_tready <= ($urandom_range(0, 99) >= 74);
				IDLE_BOTH: m_tready <= ($urandom_range(0, 99) >= 30);
				default: m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.accepted = m_tdata[0];
			got.mission_active = m_tdata[1];
			got.target_valid = m_tdata[2];
			got.target.x = m_tdata[26:3];
			got.target.y = m_tdata[50:27];
			got.target.z = m_tdata[74:51];
			got.waypoint_count = m_tdata[75 +: COUNT_W];
			if (status_due.size() == 0) begin
				$display("%0t ns: result word with nothing expected, got %h", $time, m_tdata);
				error_count++;
			end else begin
				status_t want;
				want = status_due.pop_front();
				check_field("accepted", want.accepted, got.accepted);
				check_field("mission_active", want.mission_active, got.mission_active);
				check_field("target_valid", want.target_valid, got.target_valid);
				check_field("target_x", $signed(want.target.x), $signed(got.target.x));
				check_field("target_y", $signed(want.target.y), $signed(got.target.y));
				check_field("target_z", $signed(want.target.z), $signed(got.target.z));
				check_field("waypoint_count", want.waypoint_count, got.waypoint_count);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles", $time, stall_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [wqm_pkg::MODE_W-1:0] mode;
		wqm_pkg::point_t p;
		dir_tab = {
			w_row_exp(wqm_pkg::MODE_POSE, 0, 0, 0, 1'b1),
			w_row_exp(wqm_pkg::MODE_CANCEL, 0, 0, 0, 1'b1),
			w_row_exp(MODE_UNUSED, 5, 5, 5, 1'b0),
			w_row_exp(wqm_pkg::MODE_ADD, -8388608, 0, 0, 1'b0),
			w_row_exp(wqm_pkg::MODE_ADD, 0, 0, 12800, 1'b0),
			w_row(wqm_pkg::MODE_ADD, 63999, -63999, 12799),
			w_row(wqm_pkg::MODE_ADD, 64000, 0, 0),
			// exactly the spacing away from the tail: too close
			w_row(wqm_pkg::MODE_ADD, 63871, -63999, 12799),
			w_row(wqm_pkg::MODE_ADD, 63870, -63999, 12799),
			w_row(wqm_pkg::MODE_ADD, 0, 0, -12799),
			w_row(wqm_pkg::MODE_POSE, 63999, -63999, 12799),
			// exactly the reach away from the front: not reached
			w_row(wqm_pkg::MODE_POSE, 63870, -63871, 12799),
			w_row(wqm_pkg::MODE_POSE, 63743, -63999, 12799),
			w_row(wqm_pkg::MODE_POSE, 0, 0, -12799),
			w_row_exp(wqm_pkg::MODE_ADD, 8388607, 8388607, 8388607, 1'b0),
			w_row(wqm_pkg::MODE_ADD, 1000, 2000, -300),
			w_row_exp(wqm_pkg::MODE_CANCEL, 7, 7, 7, 1'b1),
			r_row(wqm_pkg::CFG_RETAIN, 1),
			w_row(wqm_pkg::MODE_ADD, 100, 100, 100),
			w_row(wqm_pkg::MODE_POSE, 100, 100, 100),
			w_row(wqm_pkg::MODE_ADD, 100, 100, 100),
			w_row(wqm_pkg::MODE_ADD, -500, 700, 200),
			w_row(wqm_pkg::MODE_ADD, 2000, 700, 200),
			w_row(wqm_pkg::MODE_POSE, -500, 700, 200),
			w_row(wqm_pkg::MODE_POSE, 1, 2, 3),
			w_row(wqm_pkg::MODE_CANCEL, 0, 0, 0),
			w_row(wqm_pkg::MODE_CANCEL, 0, 0, 0),
			r_row(wqm_pkg::CFG_RETAIN, 0)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_REG) begin
				cfg_write(dir_tab[i].reg_idx, dir_tab[i].x);
			end else begin
				p.x = wqm_pkg::coord_t'(dir_tab[i].x);
				p.y = wqm_pkg::coord_t'(dir_tab[i].y);
				p.z = wqm_pkg::coord_t'(dir_tab[i].z);
				send_word(dir_tab[i].mode, p, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			cfg_write(wqm_pkg::CFG_RETAIN, phase_cfg[ph][0]);
			cfg_write(wqm_pkg::CFG_REACH, phase_cfg[ph][1]);
			cfg_write(wqm_pkg::CFG_SPACING, phase_cfg[ph][2]);
			cfg_write(wqm_pkg::CFG_X_LIMIT, phase_cfg[ph][3]);
			cfg_write(wqm_pkg::CFG_Y_LIMIT, phase_cfg[ph][4]);
			cfg_write(wqm_pkg::CFG_Z_LIMIT, phase_cfg[ph][5]);
			idle_mode = idle_t'(ph % 4);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				make_random_word(((n / 50) % 2) == 0, mode, p);
				send_word(mode, p, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
